/* rtl/dspt_pkg.sv */
// Package for the disk sector position tracker.
// Holds request codes, geometry constants and the controller/datapath link types.
// No dependencies.
package dspt_pkg;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SEEK  = 2'd1;
  localparam logic [1:0] REQ_ADV   = 2'd2;
  localparam logic [1:0] REQ_RECAL = 2'd3;

  localparam logic [1:0] CFG_CYLINDERS = 2'd0;
  localparam logic [1:0] CFG_HEADS     = 2'd1;
  localparam logic [1:0] CFG_SPT       = 2'd2;
  localparam logic [1:0] CFG_TOTAL     = 2'd3;

  localparam logic [47:0] LBA28_LIMIT = 48'h0000_0FFF_FFFF;
  localparam logic [4:0]  HEAD_LIMIT  = 5'd16;

  localparam int unsigned MUL_A_W = 21;
  localparam int unsigned MUL_B_W = 8;
  localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;

  typedef struct packed {
    logic latch;       // capture the input beat
    logic mul_first;   // cylinder * heads
    logic mul_second;  // (product + head) * sectors_per_track
    logic commit;      // update position and load the output register
  } dspt_cmd_t;

  typedef struct packed {
    logic out_free;    // output register can take a result this cycle
  } dspt_sts_t;

endpackage

/* rtl/disk_sector_position_tracker_core.sv */
// Disk sector position tracker: keeps an ATA drive position in LBA and CHS form.
// Load, seek, advance and recalibrate requests are latched and then committed to the
// output register once free; a CHS seek first takes two steps of the one shared
// 21x8 multiplier that forms (cylinder*heads + head)*sectors_per_track. One request
// is in work at a time; a finished result waits in the output register while the
// next beat is taken. Depends on dspt_pkg, dspt_ctrl and dspt_dp.
module disk_sector_position_tracker_core
  import dspt_pkg::*;
#(
  parameter int unsigned LBA_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [79:0]  s_axis_tdata_i,   // cylinder_in, head_in, sector_in, lba_in
  input  logic [2:0]   s_axis_tuser_i,   // req_type, lba_mode
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o,   // linear_sector, cylinder_now, head_now,
                                         // sector_now, lba_now
  output logic         m_axis_tuser_o,   // fault
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_wdata_i
);

  dspt_cmd_t cmd;
  dspt_sts_t sts;

  dspt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .req_type_i (s_axis_tuser_i[1:0]),
    .lba_mode_i (s_axis_tuser_i[2]),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dspt_dp #(
    .LBA_BITS (LBA_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .out_user_o  (m_axis_tuser_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

endmodule

/* rtl/dspt_ctrl.sv */
// Controller state machine of the disk sector position tracker.
// Sequences latch, the two multiply steps and the commit; uses dspt_pkg.
module dspt_ctrl
  import dspt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] req_type_i,
  input  logic       lba_mode_i,
  output logic       in_ready_o,
  input  dspt_sts_t  sts_i,
  output dspt_cmd_t  cmd_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL1 = 2'd1;
  localparam logic [1:0] ST_MUL2 = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.latch    = accept;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_SEEK && !lba_mode_i) begin
            state_d = ST_MUL1;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_MUL1: begin
        cmd_o.mul_first = 1'b1;
        state_d         = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul_second = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/dspt_dp.sv */
// Datapath of the disk sector position tracker: geometry registers, position,
// shared multiplier for the CHS product and the output register; uses dspt_pkg.
module dspt_dp
  import dspt_pkg::*;
#(
  parameter int unsigned LBA_BITS = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dspt_cmd_t    cmd_i,
  output dspt_sts_t    sts_o,
  input  logic [79:0]  in_data_i,
  input  logic [2:0]   in_user_i,
  input  logic         out_ready_i,
  output logic         out_valid_o,
  output logic [127:0] out_data_o,
  output logic         out_user_o,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [47:0]  cfg_wdata_i
);

  localparam logic [47:0] LbaMask =
    (LBA_BITS >= 48) ? {48{1'b1}} : ((48'd1 << LBA_BITS) - 48'd1);

  // configuration
  logic [15:0] cylinders_q;
  logic [4:0]  heads_q;
  logic [7:0]  spt_q;
  logic [47:0] total_q;

  // position
  logic [47:0] pos_lba_q, pos_lba_d;
  logic [15:0] pos_cyl_q, pos_cyl_d;
  logic [3:0]  pos_head_q, pos_head_d;
  logic [7:0]  pos_sec_q, pos_sec_d;

  // latched request
  logic [1:0]  req_q;
  logic        mode_q;
  logic [15:0] cyl_in_q;
  logic [3:0]  head_in_q;
  logic [7:0]  sec_in_q;
  logic [47:0] lba_in_q;

  // multiplier
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod_q, prod_d;

  // output register
  logic         out_valid_q, out_valid_d;
  logic [127:0] out_data_q;
  logic         out_user_q;

  logic        fault;
  logic [47:0] linear;
  logic        chs_bad;
  logic [29:0] chs_sum;
  logic [4:0]  hmax;
  logic [4:0]  next_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cylinders_q <= 16'd0;
      heads_q     <= 5'd16;
      spt_q       <= 8'd63;
      total_q     <= 48'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CYLINDERS: cylinders_q <= cfg_wdata_i[15:0];
        CFG_HEADS:     heads_q     <= cfg_wdata_i[4:0];
        CFG_SPT:       spt_q       <= cfg_wdata_i[7:0];
        CFG_TOTAL:     total_q     <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q     <= in_user_i[1:0];
      mode_q    <= in_user_i[2];
      cyl_in_q  <= in_data_i[15:0];
      head_in_q <= in_data_i[19:16];
      sec_in_q  <= in_data_i[27:20];
      lba_in_q  <= in_data_i[75:28];
    end
    prod_q <= prod_d;
  end

  always_comb begin
    if (cmd_i.mul_second) begin
      mul_a = prod_q[MUL_A_W-1:0] + {{(MUL_A_W-4){1'b0}}, pos_head_q};
      mul_b = spt_q;
    end else begin
      mul_a = {{(MUL_A_W-16){1'b0}}, pos_cyl_q};
      mul_b = {{(MUL_B_W-5){1'b0}}, heads_q};
    end
    prod_d = prod_q;
    if (cmd_i.mul_first || cmd_i.mul_second) begin
      prod_d = {{(PROD_W-MUL_A_W){1'b0}}, mul_a} * {{(PROD_W-MUL_B_W){1'b0}}, mul_b};
    end
  end

  assign chs_bad = (pos_cyl_q >= cylinders_q) || ({1'b0, pos_head_q} >= heads_q) ||
                   (pos_sec_q > spt_q) || (pos_sec_q == 8'd0);
  assign chs_sum = {1'b0, prod_q} + {22'd0, pos_sec_q} - 30'd1;
  assign hmax      = (heads_q > HEAD_LIMIT) ? HEAD_LIMIT : heads_q;
  assign next_head = {1'b0, pos_head_q} + 5'd1;

  always_comb begin
    pos_lba_d  = pos_lba_q;
    pos_cyl_d  = pos_cyl_q;
    pos_head_d = pos_head_q;
    pos_sec_d  = pos_sec_q;
    fault      = 1'b0;
    linear     = 48'd0;
    unique case (req_q)
      REQ_LOAD: begin
        pos_lba_d  = (total_q > LBA28_LIMIT) ? (lba_in_q & LbaMask)
                                             : (lba_in_q & LBA28_LIMIT);
        pos_cyl_d  = cyl_in_q;
        pos_head_d = head_in_q;
        pos_sec_d  = sec_in_q;
      end
      REQ_SEEK: begin
        if (mode_q) begin
          fault  = (pos_lba_q >= total_q);
          linear = fault ? 48'd0 : pos_lba_q;
        end else begin
          fault  = chs_bad;
          linear = fault ? 48'd0 : {18'd0, chs_sum};
        end
      end
      REQ_ADV: begin
        if (mode_q) begin
          pos_lba_d = (pos_lba_q + 48'd1) & LbaMask;
        end else if (pos_sec_q < spt_q) begin
          pos_sec_d = pos_sec_q + 8'd1;
        end else begin
          pos_sec_d = 8'd1;
          if (next_head < hmax) begin
            pos_head_d = next_head[3:0];
          end else begin
            pos_head_d = 4'd0;
            pos_cyl_d  = pos_cyl_q + 16'd1;
          end
        end
      end
      REQ_RECAL: begin
        pos_lba_d  = 48'd0;
        pos_cyl_d  = 16'd0;
        pos_head_d = 4'd0;
        pos_sec_d  = 8'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_lba_q  <= 48'd0;
      pos_cyl_q  <= 16'd0;
      pos_head_q <= 4'd0;
      pos_sec_q  <= 8'd1;
    end else if (cmd_i.commit) begin
      pos_lba_q  <= pos_lba_d;
      pos_cyl_q  <= pos_cyl_d;
      pos_head_q <= pos_head_d;
      pos_sec_q  <= pos_sec_d;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_data_q <= {4'd0, pos_lba_d, pos_sec_d, pos_head_d, pos_cyl_d, linear};
      out_user_q <= fault;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

/* rtl/dspt_chk.sv */
// Port-level checker for disk_sector_position_tracker_core, bound to the top level.
// Uses only the top-level ports.
module dspt_chk (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [127:0] m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  // one request in work at a time
  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a request is in work");

  a_fault_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[47:0] == 48'd0)
    else $error("fault beat with nonzero linear sector");

  a_no_out_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result beat changed");

endmodule

bind disk_sector_position_tracker_core dspt_chk u_dspt_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* test/disk_sector_position_tracker_core_tb.sv */
// Self-checking testbench for disk_sector_position_tracker_core: stream driver and monitor
// with a beat-level position predictor, random stalls and geometry changes between phases.
// Depends on dspt_pkg and the tracker RTL.
module disk_sector_position_tracker_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dspt_pkg::*;

  localparam int unsigned RUN_LIMIT    = 300000;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned NUM_PHASES   = 7;
  localparam int unsigned HOLD_PHASE   = 3;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct packed {
    logic [1:0]  req;
    logic        lba_mode;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [7:0]  sect;
    logic [47:0] lba;
  } pos_req_t;

  typedef struct packed {
    logic        fault;
    logic [47:0] linear;
    logic [15:0] cyl;
    logic [3:0]  head;
    logic [7:0]  sect;
    logic [47:0] lba;
  } pos_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [79:0]  s_axis_tdata_i = '0;
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  logic [127:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;
  logic         cfg_we_i = 1'b0;
  logic [1:0]   cfg_idx_i = CFG_CYLINDERS;
  logic [47:0]  cfg_wdata_i = '0;

  disk_sector_position_tracker_core u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  pos_req_t    req_q[$];
  pos_res_t    pos_exp_q[$];
  int unsigned err_cnt = 0;
  int unsigned res_cnt = 0;
  int unsigned fault_cnt = 0;
  int unsigned seek_ok_cnt = 0;
  int unsigned phase_no = 0;
  int unsigned cyc_cnt = 0;
  logic        burst_mode = 1'b0;
  logic        hold_on = 1'b0;
  logic        in_fire = 1'b0;
  logic        out_fire = 1'b0;
  int unsigned in_wait = 0;
  int unsigned out_wait = 0;

  // Geometry as the block sees it, and position tracked beat by beat
  logic [15:0] geo_cyls;
  logic [4:0]  geo_heads;
  logic [7:0]  geo_spt;
  logic [47:0] geo_total;
  logic [47:0] trk_lba;
  logic [15:0] trk_cyl;
  logic [3:0]  trk_head;
  logic [7:0]  trk_sect;

  // Geometry the stimulus is aimed at
  logic [15:0] gen_cyls = 16'd0;
  logic [4:0]  gen_heads = 5'd16;
  logic [7:0]  gen_spt = 8'd63;
  logic [47:0] gen_total = 48'd0;

  function automatic pos_res_t track_step(pos_req_t rq);
    pos_res_t    r;
    logic [63:0] prod;
    logic [4:0]  hmax;
    logic [4:0]  nh;
    r = '0;
    case (rq.req)
      REQ_LOAD: begin
        trk_lba  = (geo_total > LBA28_LIMIT) ? rq.lba : (rq.lba & LBA28_LIMIT);
        trk_cyl  = rq.cyl;
        trk_head = rq.head;
        trk_sect = rq.sect;
      end
      REQ_SEEK: begin
        if (rq.lba_mode) begin
          if (trk_lba >= geo_total) r.fault = 1'b1;
          else r.linear = trk_lba;
        end else if (trk_cyl >= geo_cyls || {1'b0, trk_head} >= geo_heads ||
                     trk_sect == 8'd0 || trk_sect > geo_spt) begin
          r.fault = 1'b1;
        end else begin
          prod = (64'(trk_cyl) * 64'(geo_heads) + 64'(trk_head)) * 64'(geo_spt)
                 + 64'(trk_sect) - 64'd1;
          r.linear = prod[47:0];
        end
      end
      REQ_ADV: begin
        if (rq.lba_mode) begin
          trk_lba = trk_lba + 48'd1;
        end else if (trk_sect < geo_spt) begin
          trk_sect = trk_sect + 8'd1;
        end else begin
          hmax = (geo_heads > HEAD_LIMIT) ? HEAD_LIMIT : geo_heads;
          nh = {1'b0, trk_head} + 5'd1;
          trk_sect = 8'd1;
          if (nh < hmax) begin
            trk_head = nh[3:0];
          end else begin
            trk_head = 4'd0;
            trk_cyl = trk_cyl + 16'd1;
          end
        end
      end
      default: begin
        trk_lba  = '0;
        trk_cyl  = '0;
        trk_head = '0;
        trk_sect = 8'd1;
      end
    endcase
    r.cyl  = trk_cyl;
    r.head = trk_head;
    r.sect = trk_sect;
    r.lba  = trk_lba;
    return r;
  endfunction

  task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i) begin : mon
    pos_req_t rq;
    pos_res_t got;
    pos_res_t want;
    if (!rst_ni) begin
      geo_cyls  = 16'd0;
      geo_heads = 5'd16;
      geo_spt   = 8'd63;
      geo_total = 48'd0;
      trk_lba   = '0;
      trk_cyl   = '0;
      trk_head  = '0;
      trk_sect  = 8'd1;
      in_fire   = 1'b0;
      out_fire  = 1'b0;
    end else begin
      in_fire  = s_axis_tvalid_i && s_axis_tready_o;
      out_fire = m_axis_tvalid_o && m_axis_tready_i;
      if (out_fire) begin
        got.fault  = m_axis_tuser_o;
        got.linear = m_axis_tdata_o[47:0];
        got.cyl    = m_axis_tdata_o[63:48];
        got.head   = m_axis_tdata_o[67:64];
        got.sect   = m_axis_tdata_o[75:68];
        got.lba    = m_axis_tdata_o[123:76];
        res_cnt++;
        if (pos_exp_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, actual %h", $time, got);
          err_cnt++;
        end else begin
          want = pos_exp_q.pop_front();
          check_field("fault", 48'(want.fault), 48'(got.fault));
          check_field("linear_sector", want.linear, got.linear);
          check_field("cylinder_now", 48'(want.cyl), 48'(got.cyl));
          check_field("head_now", 48'(want.head), 48'(got.head));
          check_field("sector_now", 48'(want.sect), 48'(got.sect));
          check_field("lba_now", want.lba, got.lba);
          if (want.fault) fault_cnt++;
          else if (want.linear != 0) seek_ok_cnt++;
        end
      end
      if (in_fire) begin
        rq.req      = s_axis_tuser_i[1:0];
        rq.lba_mode = s_axis_tuser_i[2];
        rq.cyl      = s_axis_tdata_i[15:0];
        rq.head     = s_axis_tdata_i[19:16];
        rq.sect     = s_axis_tdata_i[27:20];
        rq.lba      = s_axis_tdata_i[75:28];
        pos_exp_q.push_back(track_step(rq));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CYLINDERS: geo_cyls  = cfg_wdata_i[15:0];
          CFG_HEADS:     geo_heads = cfg_wdata_i[4:0];
          CFG_SPT:       geo_spt   = cfg_wdata_i[7:0];
          default:       geo_total = cfg_wdata_i;
        endcase
      end
    end
  end

  always @(negedge clk_i) begin : drv
    pos_req_t it;
    logic     act;
    act = s_axis_tvalid_i;
    if (rst_ni) begin
      if (act && in_fire) begin
        act = 1'b0;
        in_wait = burst_mode ? 0 : $urandom_range(0, 9);
      end
      if (!act) begin
        if (in_wait > 0) begin
          in_wait--;
        end else if (req_q.size() > 0) begin
          it = req_q.pop_front();
          s_axis_tdata_i <= {4'b0, it.lba, it.sect, it.head, it.cyl};
          s_axis_tuser_i <= {it.lba_mode, it.req};
          act = 1'b1;
        end
      end
      s_axis_tvalid_i <= act;
    end
  end

  always @(negedge clk_i) begin : rcv
    if (rst_ni) begin
      if (out_fire) out_wait = burst_mode ? 0 : $urandom_range(0, 9);
      if (hold_on) begin
        m_axis_tready_i <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Long output stall while the sender keeps streaming
  initial begin : hold_off
    while (phase_no != HOLD_PHASE) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_on = 1'b0;
  end

  always @(posedge clk_i) begin : watchdog
    cyc_cnt++;
    if (cyc_cnt > RUN_LIMIT) begin
      $display("%0t ns: timeout with %0d results pending", $time, pos_exp_q.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic push(logic [1:0] req, logic mode, logic [15:0] cyl, logic [3:0] head,
                      logic [7:0] sect, logic [47:0] lba);
    pos_req_t it;
    it = '{req: req, lba_mode: mode, cyl: cyl, head: head, sect: sect, lba: lba};
    req_q.push_back(it);
  endtask

  task automatic wait_idle();
    while (req_q.size() != 0 || s_axis_tvalid_i || pos_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [47:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_geo(logic [15:0] cyls, logic [4:0] heads, logic [7:0] spt,
                         logic [47:0] total);
    wait_idle();
    cfg_write(CFG_CYLINDERS, 48'(cyls));
    cfg_write(CFG_HEADS, 48'(heads));
    cfg_write(CFG_SPT, 48'(spt));
    cfg_write(CFG_TOTAL, total);
    gen_cyls  = cyls;
    gen_heads = heads;
    gen_spt   = spt;
    gen_total = total;
  endtask

  // Mostly in range, often on the last legal value, sometimes one past it
  function automatic logic [63:0] pick_near(logic [63:0] lim);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (lim == 0 || r < 10) return {$urandom, $urandom};
    if (r < 70) return {$urandom, $urandom} % lim;
    if (r < 85) return lim - 64'd1;
    return lim;
  endfunction

  function automatic pos_req_t rand_req();
    pos_req_t    it;
    int unsigned r;
    logic [4:0]  hlim;
    it.req      = 2'($urandom_range(0, 3));
    it.lba_mode = 1'($urandom_range(0, 1));
    it.cyl      = 16'($urandom);
    it.head     = 4'($urandom);
    it.sect     = 8'($urandom);
    it.lba      = 48'({$urandom, $urandom});
    if ($urandom_range(0, 99) >= 10) begin
      r = $urandom_range(0, 99);
      if (r < 30) it.req = REQ_LOAD;
      else if (r < 65) it.req = REQ_SEEK;
      else if (r < 93) it.req = REQ_ADV;
      else it.req = REQ_RECAL;
      hlim = (gen_heads > HEAD_LIMIT) ? HEAD_LIMIT : gen_heads;
      it.cyl  = 16'(pick_near(64'(gen_cyls)));
      it.head = 4'(pick_near(64'(hlim)));
      it.sect = ($urandom_range(0, 19) == 0) ? 8'd0 : 8'(pick_near(64'(gen_spt)) + 64'd1);
      it.lba  = 48'(pick_near(64'(gen_total)));
    end
    return it;
  endfunction

  initial begin : stim
    logic [47:0] ones;
    ones = '1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry: no cylinders and no capacity
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_SEEK, 1'b1, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_ADV, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);

    // Capacity right at the 28-bit limit
    set_geo(16'd2, 5'd2, 8'd3, LBA28_LIMIT);
    push(REQ_LOAD, 1'b1, 16'd0, 4'd0, 8'd0, ones);
    push(REQ_SEEK, 1'b1, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_ADV, 1'b1, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_LOAD, 1'b0, 16'd1, 4'd1, 8'd3, 48'd5);
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_SEEK, 1'b1, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_ADV, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_LOAD, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_LOAD, 1'b0, 16'd0, 4'd0, 8'd4, 48'd0);
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_LOAD, 1'b0, 16'd0, 4'd2, 8'd1, 48'd0);
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_LOAD, 1'b0, 16'hFFFF, 4'hF, 8'hFF, ones);
    push(REQ_ADV, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_RECAL, 1'b1, 16'hFFFF, 4'hF, 8'hFF, ones);
    push(REQ_SEEK, 1'b0, 16'hFFFF, 4'hF, 8'hFF, ones);

    // 48-bit capacity, zero heads and zero sectors per track
    set_geo(16'd1, 5'd0, 8'd0, ones);
    push(REQ_LOAD, 1'b1, 16'd0, 4'd0, 8'd1, ones);
    push(REQ_ADV, 1'b1, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_SEEK, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);
    push(REQ_ADV, 1'b0, 16'd0, 4'd0, 8'd0, 48'd0);

    for (int unsigned p = 1; p <= NUM_PHASES; p++) begin
      case (p)
        1: set_geo(16'd3, 5'd1, 8'd4, 48'd20);
        2: set_geo(16'hFFFF, 5'd16, 8'hFF, ones);
        3: set_geo(16'd7, 5'd5, 8'd2, 48'd100);
        4: set_geo(16'd0, 5'd31, 8'd1, 48'h0000_1000_0000);
        5: set_geo(16'd1024, 5'd15, 8'd63, LBA28_LIMIT);
        6: set_geo(16'd1, 5'd0, 8'd0, 48'd0);
        default: set_geo(16'($urandom), 5'($urandom_range(1, 16)), 8'($urandom),
                         48'({$urandom, $urandom}));
      endcase
      burst_mode = (p == HOLD_PHASE) || (p == NUM_PHASES);
      phase_no = p;
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) req_q.push_back(rand_req());
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pos_exp_q.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, pos_exp_q.size());
      err_cnt++;
    end
    $display("Checked %0d result beats over %0d geometry settings", res_cnt, NUM_PHASES + 3);
    $display("  %0d seek faults, %0d in-range seeks with nonzero sector", fault_cnt,
             seek_ok_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* disk_sector_position_tracker_core.f */
rtl/dspt_pkg.sv
rtl/dspt_ctrl.sv
rtl/dspt_dp.sv
rtl/disk_sector_position_tracker_core.sv
rtl/dspt_chk.sv
test/disk_sector_position_tracker_core_tb.sv
